// ===== rtl/assert_macros.svh =====
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal must never be high outside reset.
`define ASSERT_NEVER(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(sig)) else $error(msg);

`endif

// ===== rtl/fph_pkg.sv =====
// ----------------------------------------------------------------------------
// fph_pkg
// Types and constants of the fit-policy heap allocator.
// ----------------------------------------------------------------------------
package fph_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int HEADER_BYTES = 32;
    localparam int POOL_LIMIT   = 65536;

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int BYTE_W = $clog2(POOL_LIMIT + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SEGMENTS - 1);

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_ZERO_REQ  = 3'd2,
        ST_FREED     = 3'd3,
        ST_BAD_FREE  = 3'd4
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    localparam logic CFG_FIT_POLICY = 1'b0;
    localparam logic CFG_POOL_BYTES = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] start;
        logic [BYTE_W-1:0] size;
        logic              free;
    } seg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FMT,
        S_SCAN,
        S_GRANT,
        S_SHIFT_UP,
        S_SPLIT,
        S_FREE_SCAN,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_SHIFT_DOWN,
        S_DONE
    } state_t;

endpackage

// ===== rtl/fph_stream_if.sv =====
// ----------------------------------------------------------------------------
// fph_stream_if
// Valid/ready channel carrying either a request or a result.
// ----------------------------------------------------------------------------
interface fph_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] request_bytes;
    logic [15:0] free_address;

    modport source (output valid, command, request_bytes, free_address, input ready);
    modport sink (input valid, command, request_bytes, free_address, output ready);
endinterface

interface fph_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] address;

    modport source (output valid, status, address, input ready);
    modport sink (input valid, status, address, output ready);
endinterface

// ===== rtl/fph_seg_ram.sv =====
// ----------------------------------------------------------------------------
// fph_seg_ram
// Segment table memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fph_seg_ram
    import fph_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  seg_t             wdata,
    input  logic [IDX_W-1:0] raddr,
    output seg_t             rdata
);

    seg_t mem [MAX_SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fit_policy_heap_allocator.sv =====
// An allocate scans the segments, then shifts the table up for a split; a free scans
// for the block, checks its next and previous neighbors and shifts the table down
// once when a merge removes entries.
// One item at a time; the single segment memory port pair reads one entry per cycle.
// Reset and a pool_bytes write clear the table to one free segment
// (only entry 0 is written; the count marks the rest as unused).
// ----------------------------------------------------------------------------
// fit_policy_heap_allocator
// Segment-table pool allocator with first, next, best and worst fit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fit_policy_heap_allocator
    import fph_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    fph_req_if.sink     req,
    fph_rsp_if.source   rsp
);

    state_t state_reg, state_next;
    logic [1:0]        policy_reg;
    logic [BYTE_W-1:0] pool_reg, pool_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rover_reg, rover_next;

    logic              cmd_reg, cmd_next;
    logic [15:0]       bytes_reg, bytes_next;
    logic [15:0]       faddr_reg, faddr_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    seg_t              pseg_reg, pseg_next;
    seg_t              cur_reg, cur_next;
    seg_t              hold_reg, hold_next;
    logic [IDX_W-1:0]  sh_reg, sh_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [15:0]       out_addr_reg, out_addr_next;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    seg_t              wdata, rdata;

    fph_seg_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [16:0] cfg_pool_clamped;
    always_comb
    begin
        cfg_pool_clamped = cfg_data;
        if (cfg_data < 17'd64)
        begin
            cfg_pool_clamped = 17'd64;
        end
        else if (cfg_data > 17'(POOL_LIMIT))
        begin
            cfg_pool_clamped = 17'(POOL_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FMT;
            policy_reg    <= FIT_FIRST;
            pool_reg      <= BYTE_W'(POOL_LIMIT);
            count_reg     <= CNT_W'(1);
            rover_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_reg;
            pool_reg      <= pool_next;
            count_reg     <= count_next;
            rover_reg     <= rover_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == CFG_FIT_POLICY)
            begin
                policy_reg <= cfg_data[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        bytes_reg      <= bytes_next;
        faddr_reg      <= faddr_next;
        step_reg       <= step_next;
        ptr_reg        <= ptr_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pseg_reg       <= pseg_next;
        cur_reg        <= cur_next;
        hold_reg       <= hold_next;
        sh_reg         <= sh_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    logic [IDX_W-1:0] cnt_idx;
    logic [IDX_W-1:0] ptr_inc;
    logic             fits;
    logic [BYTE_W-1:0] need;
    logic [BYTE_W-1:0] hdr_addr;
    seg_t             merged;

    assign cnt_idx = count_reg[IDX_W-1:0];
    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.address = out_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        pool_next       = pool_reg;
        count_next      = count_reg;
        rover_next      = rover_reg;
        cmd_next        = cmd_reg;
        bytes_next      = bytes_reg;
        faddr_next      = faddr_reg;
        step_next       = step_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pseg_next       = pseg_reg;
        cur_next        = cur_reg;
        hold_next       = hold_reg;
        sh_next         = sh_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;
        raddr           = ptr_reg;
        ptr_inc         = (32'(ptr_reg) + 1 >= 32'(count_reg)) ? '0 : ptr_reg + 1'b1;
        fits            = rdata.free && rdata.size >= BYTE_W'(bytes_reg);
        need            = BYTE_W'(bytes_reg) + BYTE_W'(HEADER_BYTES);
        hdr_addr        = BYTE_W'(faddr_reg);
        merged          = cur_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cmd_next   = req.command;
                    bytes_next = req.request_bytes;
                    faddr_next = req.free_address;
                    found_next = 1'b0;
                    step_next  = '0;
                    if (req.command == CMD_ALLOC)
                    begin
                        if (req.request_bytes == 16'd0)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_ZERO_REQ;
                            out_addr_next   = '0;
                        end
                        else
                        begin
                            if (policy_reg == FIT_NEXT && 32'(rover_reg) < 32'(count_reg))
                            begin
                                ptr_next = rover_reg;
                            end
                            else
                            begin
                                ptr_next = '0;
                            end
                            raddr      = ptr_next;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        ptr_next   = '0;
                        raddr      = '0;
                        state_next = S_FREE_SCAN;
                    end
                end
            end

            S_FMT:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata.start = '0;
                wdata.size  = pool_reg - BYTE_W'(HEADER_BYTES);
                wdata.free  = 1'b1;
                count_next = CNT_W'(1);
                rover_next = '0;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                // rdata holds the entry at ptr_reg.
                step_next = step_reg + 1'b1;
                raddr     = ptr_inc;
                ptr_next  = ptr_inc;
                if (fits)
                begin
                    case (policy_reg)
                        FIT_FIRST, FIT_NEXT:
                        begin
                            found_next = 1'b1;
                            pick_next  = ptr_reg;
                            pseg_next  = rdata;
                            state_next = S_GRANT;
                        end
                        FIT_BEST:
                        begin
                            if (rdata.size == BYTE_W'(bytes_reg))
                            begin
                                found_next = 1'b1;
                                pick_next  = ptr_reg;
                                pseg_next  = rdata;
                                state_next = S_GRANT;
                            end
                            else if (!found_reg || rdata.size < pseg_reg.size)
                            begin
                                found_next = 1'b1;
                                pick_next  = ptr_reg;
                                pseg_next  = rdata;
                            end
                        end
                        default:
                        begin
                            if (!found_reg || rdata.size > pseg_reg.size)
                            begin
                                found_next = 1'b1;
                                pick_next  = ptr_reg;
                                pseg_next  = rdata;
                            end
                        end
                    endcase
                end
                if (state_next == S_SCAN && step_reg + 1'b1 == count_reg)
                begin
                    state_next = S_GRANT;
                end
            end

            S_GRANT:
            begin
                if (!found_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_NO_FIT;
                    out_addr_next   = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    if (policy_reg == FIT_NEXT)
                    begin
                        rover_next = pick_reg;
                    end
                    out_status_next = ST_ALLOCATED;
                    out_addr_next   = 16'(pseg_reg.start + BYTE_W'(HEADER_BYTES));
                    if (pseg_reg.size > need && 32'(count_reg) < MAX_SEGMENTS)
                    begin
                        sh_next    = cnt_idx;
                        raddr      = cnt_idx - 1'b1;
                        state_next = (cnt_idx - 1'b1 == pick_reg) ? S_SPLIT : S_SHIFT_UP;
                        if (state_next == S_SHIFT_UP)
                        begin
                            raddr = cnt_idx - 1'b1;
                        end
                    end
                    else
                    begin
                        we          = 1'b1;
                        waddr       = pick_reg;
                        wdata       = pseg_reg;
                        wdata.free  = 1'b0;
                        out_valid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_SHIFT_UP:
            begin
                // Entry sh_reg-1 is on rdata; move it up one place.
                we    = 1'b1;
                waddr = sh_reg;
                wdata = rdata;
                sh_next = sh_reg - 1'b1;
                raddr = sh_reg - 2'd2;
                if (sh_reg - 2'd2 == pick_reg)
                begin
                    state_next = S_SPLIT;
                end
            end

            S_SPLIT:
            begin
                we          = 1'b1;
                waddr       = pick_reg;
                wdata.start = pseg_reg.start;
                wdata.size  = BYTE_W'(bytes_reg);
                wdata.free  = 1'b0;
                hold_next.start = pseg_reg.start + need;
                hold_next.size  = pseg_reg.size - need;
                hold_next.free  = 1'b1;
                sh_next         = pick_reg + 1'b1;
                count_next      = count_reg + 1'b1;
                if (rover_next > pick_reg)
                begin
                    rover_next = rover_next + 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                we             = 1'b1;
                waddr          = sh_reg;
                wdata          = hold_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            S_FREE_SCAN:
            begin
                step_next  = step_reg + 1'b1;
                raddr      = ptr_reg + 1'b1;
                ptr_next   = ptr_reg + 1'b1;
                if (rdata.start + BYTE_W'(HEADER_BYTES) == hdr_addr)
                begin
                    if (rdata.free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_BAD_FREE;
                        out_addr_next   = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        pick_next = ptr_reg;
                        cur_next  = rdata;
                        cur_next.free = 1'b1;
                        state_next = S_FREE_NEXT;
                    end
                end
                else if (step_reg + 1'b1 == count_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_BAD_FREE;
                    out_addr_next   = '0;
                    state_next      = S_IDLE;
                end
            end

            S_FREE_NEXT:
            begin
                // rdata holds entry pick+1 (meaningful only if it exists).
                found_next = 1'b0;
                if (32'(pick_reg) + 1 < 32'(count_reg) && rdata.free)
                begin
                    merged.size = cur_reg.size + rdata.size + BYTE_W'(HEADER_BYTES);
                    cur_next    = merged;
                    if (rover_reg == pick_reg + 1'b1)
                    begin
                        rover_next = pick_reg;
                    end
                    else if (rover_reg > pick_reg + 1'b1)
                    begin
                        rover_next = rover_reg - 1'b1;
                    end
                    count_next = count_reg - 1'b1;
                    found_next = 1'b1;
                end
                raddr = pick_reg - 1'b1;
                state_next = S_FREE_PREV;
            end

            S_FREE_PREV:
            begin
                // rdata is entry pick-1; write pick-1 if it is free, else pick.
                sh_next = pick_reg + 1'b1;
                if (pick_reg != '0 && rdata.free)
                begin
                    we          = 1'b1;
                    waddr       = pick_reg - 1'b1;
                    wdata       = rdata;
                    wdata.size  = rdata.size + cur_reg.size + BYTE_W'(HEADER_BYTES);
                    if (rover_reg == pick_reg)
                    begin
                        rover_next = pick_reg - 1'b1;
                    end
                    else if (rover_reg > pick_reg)
                    begin
                        rover_next = rover_reg - 1'b1;
                    end
                    count_next = count_reg - 1'b1;
                    // Removed slots: pick (and pick+1 if merged forward).
                    sh_next   = pick_reg;
                    step_next = found_reg ? CNT_W'(2) : CNT_W'(1);
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = pick_reg;
                    wdata     = cur_reg;
                    sh_next   = pick_reg + 1'b1;
                    step_next = found_reg ? CNT_W'(1) : CNT_W'(0);
                end
                raddr = (sh_next + step_next[IDX_W-1:0]);
                if (step_next == '0 || 32'(sh_next) >= 32'(count_next))
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_FREED;
                    out_addr_next   = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_SHIFT_DOWN;
                end
            end

            S_SHIFT_DOWN:
            begin
                // rdata holds entry sh+step; move it to sh.
                we      = 1'b1;
                waddr   = sh_reg;
                wdata   = rdata;
                sh_next = sh_reg + 1'b1;
                raddr   = sh_reg + 1'b1 + step_reg[IDX_W-1:0];
                if (32'(sh_reg) + 1 >= 32'(count_reg))
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_FREED;
                    out_addr_next   = '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we && cfg_index == CFG_POOL_BYTES)
        begin
            pool_next  = cfg_pool_clamped;
            state_next = S_FMT;
        end
    end

    `ASSERT_CLK(a_count_range, clk, rst_n,
        (count_reg >= CNT_W'(1) && 32'(count_reg) <= MAX_SEGMENTS), "segment count out of range")
    `ASSERT_CLK(a_ready_idle, clk, rst_n,
        (req.ready |-> state_reg == S_IDLE), "ready outside idle")
    `ASSERT_CLK(a_one_result, clk, rst_n,
        (req.valid && req.ready |=> !rsp.valid || $past(!rsp.valid)), "result before request")

endmodule

// ===== tb/sv/tb_fit_policy_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_fit_policy_heap_allocator
// Self-checking testbench of the fit-policy heap allocator. A behavioral
// model of the segment table predicts the status and address of every
// request. Directed tests cover zero and oversized requests, bad and double
// frees, each fit policy and pool size clamping. Random traffic then mixes
// allocates, frees of live blocks and bad frees under several pool sizes and idling
// regimes, including a long output stall.
// ----------------------------------------------------------------------------
module tb_fit_policy_heap_allocator;
    import fph_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        status_t     status;
        logic [15:0] address;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_FIT_POLICY;
    logic [16:0] cfg_data = '0;

    fph_req_if req ();
    fph_rsp_if rsp ();

    fit_policy_heap_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    // Allocator model state.
    int          seg_start [MAX_SEGMENTS];
    int          seg_size [MAX_SEGMENTS];
    bit          seg_free [MAX_SEGMENTS];
    int          seg_count;
    int          rover;
    fit_t        policy;
    int          pool_size;

    outcome_t    pending [$];
    logic [15:0] live_blocks [$];
    logic [15:0] last_freed;
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    always #1 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.command = CMD_ALLOC;
        req.request_bytes = '0;
        req.free_address = '0;
        rsp.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready = 1'b0;
        else if (hold_cycles > 0)
        begin
            rsp.ready = 1'b0;
            hold_cycles--;
        end
        else
            rsp.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status %0d address %0d", $time,
                         rsp.status, rsp.address);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (rsp.status !== want.status || rsp.address !== want.address)
                begin
                    $display("%0t: expected status %0d address %0d, got status %0d address %0d",
                             $time, want.status, want.address, rsp.status, rsp.address);
                    errors++;
                end
            end
        end
    end

    function automatic void format_pool();
        seg_start[0] = 0;
        seg_size[0] = pool_size - HEADER_BYTES;
        seg_free[0] = 1'b1;
        seg_count = 1;
        rover = 0;
        live_blocks.delete();
    endfunction

    function automatic bit fits(int i, int bytes);
        return seg_free[i] && seg_size[i] >= bytes;
    endfunction

    function automatic void drop_segment(int i);
        for (int k = i; k + 1 < seg_count; k++)
        begin
            seg_start[k] = seg_start[k + 1];
            seg_size[k] = seg_size[k + 1];
            seg_free[k] = seg_free[k + 1];
        end
        seg_count--;
        if (rover > i)
            rover--;
    endfunction

    function automatic int choose_segment(int bytes);
        int pick;
        int first;
        int j;
        pick = -1;
        if (policy == FIT_NEXT)
        begin
            first = (rover < seg_count) ? rover : 0;
            for (int i = 0; i < seg_count; i++)
            begin
                j = (first + i) % seg_count;
                if (fits(j, bytes))
                begin
                    rover = j;
                    return j;
                end
            end
            return -1;
        end
        for (int i = 0; i < seg_count; i++)
        begin
            if (fits(i, bytes))
            begin
                if (policy == FIT_FIRST)
                    return i;
                if (policy == FIT_BEST)
                begin
                    if (seg_size[i] == bytes)
                        return i;
                    if (pick < 0 || seg_size[i] < seg_size[pick])
                        pick = i;
                end
                else if (pick < 0 || seg_size[i] > seg_size[pick])
                    pick = i;
            end
        end
        return pick;
    endfunction

    function automatic outcome_t allocate_block(int bytes);
        outcome_t res;
        int i;
        res.status = ST_ALLOCATED;
        res.address = '0;
        if (bytes == 0)
        begin
            res.status = ST_ZERO_REQ;
            return res;
        end
        i = choose_segment(bytes);
        if (i < 0)
        begin
            res.status = ST_NO_FIT;
            return res;
        end
        seg_free[i] = 1'b0;
        if (seg_size[i] > bytes + HEADER_BYTES && seg_count < MAX_SEGMENTS)
        begin
            for (int k = seg_count; k > i + 1; k--)
            begin
                seg_start[k] = seg_start[k - 1];
                seg_size[k] = seg_size[k - 1];
                seg_free[k] = seg_free[k - 1];
            end
            seg_start[i + 1] = seg_start[i] + HEADER_BYTES + bytes;
            seg_size[i + 1] = seg_size[i] - bytes - HEADER_BYTES;
            seg_free[i + 1] = 1'b1;
            seg_size[i] = bytes;
            seg_count++;
            if (rover > i)
                rover++;
        end
        res.address = 16'(seg_start[i] + HEADER_BYTES);
        live_blocks.push_back(res.address);
        return res;
    endfunction

    function automatic outcome_t release_block(logic [15:0] addr);
        outcome_t res;
        int i;
        res.address = '0;
        for (i = 0; i < seg_count; i++)
            if (seg_start[i] + HEADER_BYTES == int'(addr))
                break;
        if (i == seg_count || seg_free[i])
        begin
            res.status = ST_BAD_FREE;
            return res;
        end
        seg_free[i] = 1'b1;
        if (i + 1 < seg_count && seg_free[i + 1])
        begin
            if (rover == i + 1)
                rover = i;
            seg_size[i] += seg_size[i + 1] + HEADER_BYTES;
            drop_segment(i + 1);
        end
        if (i > 0 && seg_free[i - 1])
        begin
            if (rover == i)
                rover = i - 1;
            seg_size[i - 1] += seg_size[i] + HEADER_BYTES;
            drop_segment(i);
        end
        foreach (live_blocks[k])
            if (live_blocks[k] == addr)
            begin
                live_blocks.delete(k);
                break;
            end
        last_freed = addr;
        res.status = ST_FREED;
        return res;
    endfunction

    task automatic send_request(command_t cmd, logic [15:0] bytes, logic [15:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.command = cmd;
        req.request_bytes = bytes;
        req.free_address = addr;
        do
            @(posedge clk);
        while (!req.ready);
        if (cmd == CMD_ALLOC)
            pending.push_back(allocate_block(int'(bytes)));
        else
            pending.push_back(release_block(addr));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req.valid = 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic index, logic [16:0] value);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (index == CFG_FIT_POLICY)
            policy = fit_t'(value[1:0]);
        else
        begin
            pool_size = int'(value);
            if (pool_size < 64)
                pool_size = 64;
            if (pool_size > POOL_LIMIT)
                pool_size = POOL_LIMIT;
            format_pool();
        end
    endtask

    task automatic test_zero_and_oversize();
        send_request(CMD_ALLOC, 16'd0, 16'd0);
        send_request(CMD_ALLOC, 16'hFFFF, 16'd0);
        send_request(CMD_ALLOC, 16'(POOL_LIMIT - HEADER_BYTES), 16'd0);
        send_request(CMD_FREE, 16'd0, 16'(HEADER_BYTES));
        send_request(CMD_FREE, 16'd0, 16'(HEADER_BYTES));
        send_request(CMD_FREE, 16'd0, 16'd0);
        send_request(CMD_FREE, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_fit_policies();
        logic [15:0] first_block;
        logic [15:0] third_block;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_FIT_POLICY, 17'(p));
            write_reg(CFG_POOL_BYTES, 17'd1024);
            send_request(CMD_ALLOC, 16'd64, 16'd0);
            first_block = live_blocks[$];
            send_request(CMD_ALLOC, 16'd128, 16'd0);
            send_request(CMD_ALLOC, 16'd96, 16'd0);
            third_block = live_blocks[$];
            send_request(CMD_ALLOC, 16'd16, 16'd0);
            send_request(CMD_FREE, 16'd0, first_block);
            send_request(CMD_FREE, 16'd0, third_block);
            send_request(CMD_ALLOC, 16'd64, 16'd0);
            send_request(CMD_ALLOC, 16'd40, 16'd0);
        end
    endtask

    task automatic test_pool_clamp();
        write_reg(CFG_POOL_BYTES, 17'd0);
        send_request(CMD_ALLOC, 16'd32, 16'd0);
        send_request(CMD_ALLOC, 16'd1, 16'd0);
        send_request(CMD_FREE, 16'd0, 16'(HEADER_BYTES));
        write_reg(CFG_POOL_BYTES, 17'h1FFFF);
        send_request(CMD_ALLOC, 16'(POOL_LIMIT - HEADER_BYTES), 16'd0);
    endtask

    task automatic run_random_traffic(int count);
        int roll;
        logic [15:0] bytes;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55 || live_blocks.size() == 0 && roll < 90)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    bytes = 16'($urandom_range(1, 256));
                else if (roll < 90)
                    bytes = 16'($urandom_range(1, 4096));
                else if (roll < 95)
                    bytes = 16'd0;
                else
                    bytes = 16'($urandom);
                send_request(CMD_ALLOC, bytes, 16'($urandom));
            end
            else if (roll < 90)
                send_request(CMD_FREE, 16'($urandom),
                             live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            else if (roll < 95)
                send_request(CMD_FREE, 16'($urandom), last_freed);
            else
                send_request(CMD_FREE, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random_regime(int idle_pct, int stall_pct, bit long_hold);
        int pools [4] = '{65536, 2048, 4096, 3000};
        wait_idle();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_FIT_POLICY, 17'(p));
            write_reg(CFG_POOL_BYTES, 17'(pools[(p + idle_pct) % 4]));
            if (long_hold && p == 1)
                hold_cycles = 500;
            run_random_traffic(140);
        end
    endtask

    initial
    begin
        policy = FIT_FIRST;
        pool_size = POOL_LIMIT;
        last_freed = '0;
        format_pool();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_zero_and_oversize();
        test_fit_policies();
        test_pool_clamp();
        test_random_regime(15, 83, 1'b0);
        test_random_regime(83, 15, 1'b0);
        test_random_regime(0, 0, 1'b1);
        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fph_pkg.sv
rtl/fph_stream_if.sv
rtl/fph_seg_ram.sv
rtl/fit_policy_heap_allocator.sv
tb/sv/tb_fit_policy_heap_allocator.sv
